[hdl/iaie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaie_pkg
// Shared types and constants for the indexed array insert/erase block.
// ----------------------------------------------------------------------------
package iaie_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_SET    = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOVE,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [6:0]         position;
      logic signed [31:0] value;
      logic [6:0]         amount;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               read_valid;
      logic [6:0]         length;
      logic [7:0]         room;
      status_type         status;
   } rsp_type;

endpackage

[hdl/iaie_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaie_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module iaie_ram #(
   parameter int WIDTH = iaie_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DEPTH = iaie_pkg::DEPTH_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/indexed_array_insert_erase.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_insert_erase
// Ordered array of signed values with insert, erase, set and get by position.
// ----------------------------------------------------------------------------
// The array lives in one single-write, single-read RAM; entries at or
// above the length never reach a response, so the RAM needs no clearing
// after reset. One request is worked on at a time. Set, get, any rejected
// request, an insert at the end and an erase that moves nothing go from
// idle straight to the finish state, where the response is loaded. An
// insert at position p moves length-p entries up; an erase of d entries at
// p moves length-p-d entries down; both pass the move and drain states
// before the finish state. The move loop reads one entry and writes one
// entry per cycle, so the RAM's single write port sets its pace. The
// response sits in an output register, so the next request is taken while
// a response is still stalled. Room is a modeled capacity: it starts at 1
// and doubles whenever an insert makes the length reach it.
// ----------------------------------------------------------------------------
module indexed_array_insert_erase #(
   parameter int DEPTH       = iaie_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = iaie_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iaie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iaie_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);         // RAM address
   localparam int CW = $clog2(DEPTH + 1);     // length, 0..DEPTH
   localparam int RW = CW + 1;                // room, up to 2**CW
   localparam int LW = (CW > 7) ? CW : 7;     // compare width for positions

   // control state
   iaie_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [RW-1:0]        room_ff, room_in;
   logic                 pend_ff, pend_in;      // move write outstanding
   logic                 rsp_valid_ff, rsp_valid_in;

   // request context
   iaie_pkg::op_type     op_ff, op_in;
   iaie_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [AW-1:0]        dst_ff, dst_in;
   logic [AW-1:0]        pend_dst_ff, pend_dst_in;
   logic [CW-1:0]        left_ff, left_in;
   logic                 asc_ff, asc_in;
   iaie_pkg::rsp_type    rsp_ff, rsp_in;

   // RAM port
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [VALUE_WIDTH-1:0] ram_q;

   // request decode
   logic [LW-1:0] pos_l, cnt_l, amt_l;
   logic [LW-1:0] avail_l, del_l, moves_l, cnt_less_l, cnt_minus1_l, src_up_l;
   logic [63:0]   val_wide, rd_wide, len_wide, room_wide;
   logic [RW-1:0] room_grown;
   logic          out_free;

   iaie_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign pos_l        = LW'(req_data.position);
   assign cnt_l        = LW'(count_ff);
   assign amt_l        = LW'(req_data.amount);
   assign avail_l      = cnt_l - pos_l;
   assign del_l        = (amt_l < avail_l) ? amt_l : avail_l;
   assign moves_l      = avail_l - del_l;
   assign cnt_less_l   = cnt_l - del_l;
   assign cnt_minus1_l = cnt_l - LW'(1);
   assign src_up_l     = pos_l + del_l;
   assign val_wide     = 64'(signed'(req_data.value));
   assign rd_wide      = 64'(signed'(ram_q));
   assign len_wide     = 64'(count_ff);
   assign room_wide    = 64'(room_ff);
   assign room_grown   = ((RW'(count_ff) + RW'(1)) == room_ff) ? (room_ff << 1) : room_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != iaie_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      room_in      = room_ff;
      pend_in      = 1'b0;
      pend_dst_in  = pend_dst_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      left_in      = left_ff;
      asc_in       = asc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // trailing write of the move loop by default
      ram_we    = pend_ff;
      ram_waddr = pend_dst_ff;
      ram_wdata = ram_q;
      ram_re    = 1'b0;
      ram_raddr = src_ff;

      case (state_ff)
         iaie_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               pos_in    = pos_l[AW-1:0];
               val_in    = val_wide[VALUE_WIDTH-1:0];
               status_in = iaie_pkg::ST_OK;
               state_in  = iaie_pkg::S_FINISH;
               case (req_data.op)
                  iaie_pkg::OP_INSERT: begin
                     if (pos_l > cnt_l) begin
                        status_in = iaie_pkg::ST_BAD_POS;
                     end else if (cnt_l >= LW'(DEPTH)) begin
                        status_in = iaie_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        room_in  = room_grown;
                        // shift entries up, from the top down
                        src_in   = cnt_minus1_l[AW-1:0];
                        dst_in   = cnt_l[AW-1:0];
                        left_in  = avail_l[CW-1:0];
                        asc_in   = 1'b0;
                        if (avail_l != '0) begin
                           state_in = iaie_pkg::S_MOVE;
                        end
                     end
                  end
                  iaie_pkg::OP_ERASE: begin
                     if (pos_l > cnt_l) begin
                        status_in = iaie_pkg::ST_BAD_POS;
                     end else begin
                        count_in = cnt_less_l[CW-1:0];
                        // pull later entries down, bottom up
                        src_in   = src_up_l[AW-1:0];
                        dst_in   = pos_l[AW-1:0];
                        left_in  = moves_l[CW-1:0];
                        asc_in   = 1'b1;
                        if ((del_l != '0) && (moves_l != '0)) begin
                           state_in = iaie_pkg::S_MOVE;
                        end
                     end
                  end
                  iaie_pkg::OP_SET: begin
                     if (pos_l >= cnt_l) begin
                        status_in = iaie_pkg::ST_BAD_POS;
                     end
                  end
                  default: begin
                     if (pos_l >= cnt_l) begin
                        status_in = iaie_pkg::ST_BAD_POS;
                     end
                     ram_re    = 1'b1;
                     ram_raddr = pos_l[AW-1:0];
                  end
               endcase
            end
         end

         iaie_pkg::S_MOVE: begin
            ram_re      = 1'b1;
            ram_raddr   = src_ff;
            pend_in     = 1'b1;
            pend_dst_in = dst_ff;
            src_in      = asc_ff ? src_ff + AW'(1) : src_ff - AW'(1);
            dst_in      = asc_ff ? dst_ff + AW'(1) : dst_ff - AW'(1);
            left_in     = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               state_in = iaie_pkg::S_DRAIN;
            end
         end

         iaie_pkg::S_DRAIN: begin
            state_in = iaie_pkg::S_FINISH;
         end

         iaie_pkg::S_FINISH: begin
            // repeated while the output is blocked; same entry, same data
            if ((op_ff inside {iaie_pkg::OP_INSERT, iaie_pkg::OP_SET}) &&
                (status_ff == iaie_pkg::ST_OK)) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = val_ff;
            end
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_valid = (op_ff == iaie_pkg::OP_GET) &&
                                   (status_ff == iaie_pkg::ST_OK);
               rsp_in.read_value = rsp_in.read_valid ? signed'(rd_wide[31:0]) : '0;
               rsp_in.length     = len_wide[6:0];
               rsp_in.room       = room_wide[7:0];
               rsp_in.status     = status_ff;
               state_in          = iaie_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = iaie_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iaie_pkg::S_IDLE;
         count_ff     <= '0;
         room_ff      <= RW'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         room_ff      <= room_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      pend_dst_ff <= pend_dst_in;
      left_ff     <= left_in;
      asc_ff      <= asc_in;
      rsp_ff      <= rsp_in;
   end

   // length never passes the array size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("length above array size");

   // modeled capacity always stays above the length
   a_room_above: assert property (@(posedge clock) disable iff (reset)
      RW'(count_ff) < room_ff)
      else $error("room not above length");

   // the move loop never reads the entry it is writing back
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read and write hit the same entry");

   // a valid read comes only with an ok status
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.read_valid) |-> (rsp_data.status == iaie_pkg::ST_OK))
      else $error("read valid with error status");

endmodule

[verif/array_response_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_response_checker
// Watches both channels of the indexed array block, predicts each response
// from its own copy of the array and compares the responses field by field.
// ----------------------------------------------------------------------------
module array_response_checker #(
   parameter int DEPTH = iaie_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  iaie_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  iaie_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                outstanding
);
   import iaie_pkg::*;

   logic signed [31:0] array_copy [0:DEPTH-1];
   int unsigned        array_len;
   int unsigned        array_room;
   rsp_type            pending_responses [$];
   rsp_type            oldest;

   // Applies one request to the local array and returns its response.
   function automatic rsp_type apply_array_op(input req_type r);
      rsp_type     res;
      int unsigned n;
      int unsigned del;
      res        = '0;
      res.status = ST_OK;
      case (r.op)
         OP_INSERT: begin
            if (r.position > array_len) begin
               res.status = ST_BAD_POS;
            end else if (array_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (n = array_len; n > r.position; n--) array_copy[n] = array_copy[n-1];
               array_copy[r.position] = r.value;
               array_len++;
               while (array_len >= array_room) array_room = array_room * 2;
            end
         end
         OP_ERASE: begin
            if (r.position > array_len) begin
               res.status = ST_BAD_POS;
            end else begin
               del = array_len - 32'(r.position);
               if (r.amount < del) del = 32'(r.amount);
               for (n = r.position; n + del < array_len; n++)
                  array_copy[n] = array_copy[n+del];
               array_len -= del;
            end
         end
         OP_SET: begin
            if (r.position < array_len) array_copy[r.position] = r.value;
            else res.status = ST_BAD_POS;
         end
         default: begin
            if (r.position < array_len) begin
               res.read_value = array_copy[r.position];
               res.read_valid = 1'b1;
            end else begin
               res.status = ST_BAD_POS;
            end
         end
      endcase
      res.length = array_len[6:0];
      res.room   = array_room[7:0];
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         array_len      = 0;
         array_room     = 1;
         mismatch_count = 0;
         pending_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest = pending_responses.pop_front();
               compare_field("read_value", oldest.read_value, rsp_data.read_value);
               compare_field("read_valid", 32'(oldest.read_valid),
                             32'(rsp_data.read_valid));
               compare_field("length", 32'(oldest.length), 32'(rsp_data.length));
               compare_field("room", 32'(oldest.room), 32'(rsp_data.room));
               compare_field("status", 32'(oldest.status), 32'(rsp_data.status));
            end
         end
         if (req_valid && !req_stall) pending_responses.push_back(apply_array_op(req_data));
      end
      outstanding <= pending_responses.size();
   end

endmodule

[verif/tb_indexed_array_insert_erase.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_insert_erase
// Drives insert, erase, set and get requests into the indexed array block
// with random gaps and back-pressure; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_indexed_array_insert_erase;
   import iaie_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 800;
   // longest move (full array shifted) plus the fixed overhead
   localparam int DRAIN_CYCLES = DEPTH + 8;
   localparam int HOLD_CYCLES  = 300;

   // request mixes for the random part
   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_BALANCED,
      MIX_NOISE
   } mix_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      mismatch_count;
   int      outstanding;

   // stimulus-side estimate of the array length, used only to aim positions
   int unsigned level;
   bit          burst_mode;

   always #5 clock = ~clock;

   indexed_array_insert_erase #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   array_response_checker #(
      .DEPTH(DEPTH)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   // Length after a request, so later requests can target live positions.
   function automatic int unsigned level_after(input req_type r, input int unsigned lvl);
      int unsigned del;
      if (r.op == OP_INSERT && r.position <= lvl && lvl < DEPTH) return lvl + 1;
      if (r.op == OP_ERASE && r.position <= lvl) begin
         del = lvl - 32'(r.position);
         if (r.amount < del) del = 32'(r.amount);
         return lvl - del;
      end
      return lvl;
   endfunction

   // Mostly short gaps, now and then a long one; none inside a burst.
   function automatic int pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (burst_mode || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [6:0] pick_amount();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 7'($urandom_range(1, 3));
      if (pick < 85) return 7'($urandom_range(0, 64));
      if (pick < 95) return 7'd0;
      return 7'd64;
   endfunction

   function automatic req_type make_item(input mix_type mix);
      req_type     r;
      int unsigned pick;
      int unsigned ins_cut;
      int unsigned era_cut;
      r.value  = pick_value();
      r.amount = pick_amount();
      pick     = $urandom_range(0, 99);
      // noise: any op, any position in range, regardless of the length
      if (mix == MIX_NOISE || pick < 5) begin
         r.op       = op_type'($urandom_range(0, 3));
         r.position = 7'($urandom_range(0, 64));
         r.amount   = 7'($urandom_range(0, 64));
         return r;
      end
      case (mix)
         MIX_GROW:   begin ins_cut = 65; era_cut = 75; end
         MIX_SHRINK: begin ins_cut = 20; era_cut = 65; end
         default:    begin ins_cut = 40; era_cut = 60; end
      endcase
      if (pick < ins_cut) begin
         r.op       = OP_INSERT;
         r.position = 7'($urandom_range(0, level));
      end else if (pick < era_cut) begin
         r.op       = OP_ERASE;
         r.position = 7'($urandom_range(0, level));
      end else begin
         r.op = (pick[0]) ? OP_GET : OP_SET;
         // one in ten aims at the length itself to hit the bad-position path
         if (level == 0 || $urandom_range(0, 9) == 0) r.position = 7'(level);
         else r.position = 7'($urandom_range(0, level - 1));
      end
      return r;
   endfunction

   function automatic req_type build_req(input op_type op, input int unsigned pos,
                                         input logic [31:0] val, input int unsigned amt);
      req_type r;
      r.op       = op;
      r.position = 7'(pos);
      r.value    = val;
      r.amount   = 7'(amt);
      return r;
   endfunction

   // Offer one request, hold it until taken, then maybe idle.
   task automatic issue(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      level = level_after(r, level);
      gap   = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: alternating ready and stall stretches, plus one long hold-off
   // once the random part is underway, so the block backs up into its input.
   initial begin
      int  cycles;
      int  n;
      bit  held;
      cycles    = 0;
      held      = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(1, 60);
         rsp_stall <= 1'b0;
         repeat (n) @(posedge clock);
         cycles += n;
         if (!held && cycles > 1500) begin
            held      = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycles += HOLD_CYCLES;
         end else if ($urandom_range(0, 2) != 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            cycles += n;
         end
      end
   end

   // Stimulus
   initial begin
      int      sent;
      int      seg_len;
      bit      filled;
      mix_type mix;
      level      = 0;
      burst_mode = 1'b0;
      sent       = 0;
      filled     = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-array corner cases
      issue(build_req(OP_GET,    0, 32'h1234_5678, 0));
      issue(build_req(OP_SET,    0, 32'h1234_5678, 0));
      issue(build_req(OP_ERASE,  0, 32'h0,         5));  // at length: no-op
      issue(build_req(OP_ERASE,  1, 32'h0,         1));  // beyond length
      issue(build_req(OP_INSERT, 1, 32'h0,         0));  // beyond length
      // build a short array with extreme values, front, end and middle
      issue(build_req(OP_INSERT, 0, 32'h7fff_ffff, 0));
      issue(build_req(OP_INSERT, 0, 32'h8000_0000, 0));
      issue(build_req(OP_INSERT, 2, 32'hffff_ffff, 0));
      issue(build_req(OP_INSERT, 1, 32'h0000_0000, 0));
      for (int p = 0; p < 4; p++) issue(build_req(OP_GET, p, 32'h0, 0));
      issue(build_req(OP_SET,    3, 32'h5555_5555, 0));
      issue(build_req(OP_SET,    4, 32'haaaa_aaaa, 0));  // at length
      issue(build_req(OP_GET,    3, 32'h0,         0));
      issue(build_req(OP_GET,    4, 32'h0,         0));  // at length
      issue(build_req(OP_ERASE,  1, 32'h0,         0));  // zero amount
      issue(build_req(OP_ERASE,  1, 32'h0,         64)); // clipped at end
      issue(build_req(OP_ERASE,  2, 32'h0,         1));  // beyond length
      issue(build_req(OP_INSERT, 64, 32'h0,        0));  // far beyond
      issue(build_req(OP_GET,    0, 32'h0,         0));
      issue(build_req(OP_ERASE,  0, 32'h0,         64)); // clear

      // random segments of differing mix; one segment fills to full
      while (sent < RANDOM_ITEMS) begin
         seg_len    = $urandom_range(10, 60);
         mix        = mix_type'($urandom_range(0, 3));
         if (mix == MIX_NOISE) seg_len = seg_len / 4 + 1;
         burst_mode = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            issue(make_item(mix));
            sent++;
         end
         if (!filled && sent > 300) begin
            filled = 1'b1;
            while (level < DEPTH) begin
               issue(build_req(OP_INSERT, $urandom_range(0, level), pick_value(), 0));
               sent++;
            end
            // full array: inserts rejected, then a get and a set of the last entry
            repeat (4) begin
               issue(build_req(OP_INSERT, $urandom_range(0, 64), pick_value(), 0));
               sent++;
            end
            issue(build_req(OP_GET, 63, 32'h0, 0));
            issue(build_req(OP_SET, 63, pick_value(), 0));
            issue(build_req(OP_ERASE, 0, 32'h0, 1));     // longest move down
            issue(build_req(OP_INSERT, 0, pick_value(), 0));  // longest move up
            sent += 4;
         end
      end
      req_valid <= 1'b0;

      // let every response drain, then wait DRAIN_CYCLES more for stragglers
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("indexed_array_insert_erase regression: pass");
      end else begin
         $display("indexed_array_insert_erase regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("indexed_array_insert_erase regression: fail");
      $finish;
   end

endmodule
